[rtl/psw_pkg.sv]
// shared types, register indexes and saturation helpers for the particle step block
package psw_pkg;

    // wall register indexes on the configuration port
    localparam int unsigned REG_X_LOW  = 0;
    localparam int unsigned REG_X_HIGH = 1;
    localparam int unsigned REG_Y_LOW  = 2;
    localparam int unsigned REG_Y_HIGH = 3;
    localparam int unsigned REG_Z_LOW  = 4;
    localparam int unsigned REG_Z_HIGH = 5;
    localparam int unsigned NUM_WALLS  = 6;
    localparam int unsigned NUM_AXES   = 3;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned DT_W       = 16;

    // wall reset: +/-100.0 in Q16.16
    localparam logic signed [DATA_W-1:0] WALL_LOW_RST  = -32'sd6553600;
    localparam logic signed [DATA_W-1:0] WALL_HIGH_RST = 32'sd6553600;

    // input beat kinds
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PROD = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_SUM  = 4'b1000
    } seq_state_t;

    // stage enables from the sequencer to every lane
    typedef struct packed {
        logic capture;
        logic acc_en;
        logic sum_en;
        logic commit;
        logic is_load;
    } lane_ctrl_t;

    // clamp a 36-bit signed value into 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // negate with the minimum going to the maximum
    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] x);
        logic signed [31:0] r;
        if (x == 32'sh8000_0000) begin
            r = 32'sh7FFF_FFFF;
        end else begin
            r = -x;
        end
        return r;
    endfunction

endpackage

[rtl/psw_lane.sv]
// one axis lane: products, rounding, saturating update and wall reflection
module psw_lane (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  psw_pkg::lane_ctrl_t       ctrl,
    input  logic [psw_pkg::DT_W-1:0]  step_time,
    input  logic [31:0]               step_sq,
    input  logic signed [31:0]        accel,
    input  logic signed [31:0]        load_pos,
    input  logic signed [31:0]        load_vel,
    input  logic signed [31:0]        wall_low,
    input  logic signed [31:0]        wall_high,
    output logic signed [31:0]        pos,
    output logic signed [31:0]        vel,
    output logic                      bounce
);

    logic signed [31:0] accel_reg;
    logic signed [48:0] ad_reg;
    logic signed [48:0] vd_reg;
    logic signed [31:0] ld_pos_reg;
    logic signed [31:0] ld_vel_reg;
    logic signed [47:0] acc2_reg;
    logic signed [33:0] dv_reg;
    logic signed [34:0] dpos_reg;
    logic signed [31:0] vnew_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic               bounce_reg;
    logic signed [31:0] pos_next;
    logic signed [31:0] vel_next;
    logic               bounce_next;

    logic signed [17:0] dt_s;
    logic signed [48:0] ad_prod;
    logic signed [48:0] vd_prod;
    logic signed [64:0] acc_prod;
    logic signed [49:0] ad_rnd;
    logic signed [50:0] dpos_sum;
    logic signed [35:0] vel_sum;
    logic signed [35:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [31:0] vel_neg;

    // products taken straight from the accepted beat and current state
    assign dt_s    = {2'b00, step_time};
    assign ad_prod = 49'(accel) * 49'(dt_s);
    assign vd_prod = 49'(vel_reg) * 49'(dt_s);

    // a * dt^2, then the rounded a * dt
    assign acc_prod = accel_reg * $signed({1'b0, step_sq});
    assign ad_rnd   = {ad_reg[48], ad_reg} + 50'sd32768;

    // position delta and velocity sum
    assign dpos_sum = {{2{vd_reg[48]}}, vd_reg} + {{3{acc2_reg[47]}}, acc2_reg} + 51'sd32768;
    assign vel_sum  = {{4{vel_reg[31]}}, vel_reg} + {{2{dv_reg[33]}}, dv_reg};

    // saturated position and reflected velocity
    assign pos_sum = {{4{pos_reg[31]}}, pos_reg} + {dpos_reg[34], dpos_reg};
    assign pos_sat = psw_pkg::sat32(pos_sum);
    assign vel_neg = psw_pkg::neg_sat32(vnew_reg);

    // wall test, low wall first
    always_comb begin
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        bounce_next = bounce_reg;
        if (ctrl.commit) begin
            if (ctrl.is_load) begin
                pos_next    = ld_pos_reg;
                vel_next    = ld_vel_reg;
                bounce_next = 1'b0;
            end else if (pos_sat < wall_low) begin
                pos_next    = wall_low;
                vel_next    = vel_neg;
                bounce_next = 1'b1;
            end else if (pos_sat > wall_high) begin
                pos_next    = wall_high;
                vel_next    = vel_neg;
                bounce_next = 1'b1;
            end else begin
                pos_next    = pos_sat;
                vel_next    = vnew_reg;
                bounce_next = 1'b0;
            end
        end
    end

    // datapath stage registers
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            accel_reg  <= accel;
            ad_reg     <= ad_prod;
            vd_reg     <= vd_prod;
            ld_pos_reg <= load_pos;
            ld_vel_reg <= load_vel;
        end
        if (ctrl.acc_en) begin
            acc2_reg <= acc_prod[64:17];
            dv_reg   <= ad_rnd[49:16];
        end
        if (ctrl.sum_en) begin
            dpos_reg <= dpos_sum[50:16];
            vnew_reg <= psw_pkg::sat32(vel_sum);
        end
    end

    // particle state for this axis
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            vel_reg    <= '0;
            bounce_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            bounce_reg <= bounce_next;
        end
    end

    assign pos    = pos_reg;
    assign vel    = vel_reg;
    assign bounce = bounce_reg;

endmodule

[rtl/particle_step_with_wall_bounce.sv]
// particle step with wall bounce: three axis lanes, a sequencer and the result merge
// result path: an accepted beat runs through the product, accumulate and sum states, and the
//   result beat is registered on the commit out of the sum state, which waits while a result is held
// input: no new item is taken until the last one commits, since each lane's state feeds the next item
// reset: position and velocity clear to zero, walls return to +/-100.0, no result pending
module particle_step_with_wall_bounce (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [psw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_wdata,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [psw_pkg::DT_W-1:0]        s_step_time,
    input  logic signed [31:0]              s_accel_x,
    input  logic signed [31:0]              s_accel_y,
    input  logic signed [31:0]              s_accel_z,
    input  logic signed [31:0]              s_load_pos_x,
    input  logic signed [31:0]              s_load_pos_y,
    input  logic signed [31:0]              s_load_pos_z,
    input  logic signed [31:0]              s_load_vel_x,
    input  logic signed [31:0]              s_load_vel_y,
    input  logic signed [31:0]              s_load_vel_z,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_pos_x,
    output logic signed [31:0]              m_pos_y,
    output logic signed [31:0]              m_pos_z,
    output logic signed [31:0]              m_vel_x,
    output logic signed [31:0]              m_vel_y,
    output logic signed [31:0]              m_vel_z,
    output logic [2:0]                      m_bounce_mask
);

    psw_pkg::seq_state_t state_reg;
    psw_pkg::seq_state_t state_next;
    logic                kind_reg;
    logic [31:0]         step_sq_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic signed [31:0]  walls_reg [psw_pkg::NUM_WALLS];
    psw_pkg::lane_ctrl_t lane_ctrl;
    logic                in_beat;
    logic                commit;

    logic signed [31:0]  accel   [psw_pkg::NUM_AXES];
    logic signed [31:0]  ld_pos  [psw_pkg::NUM_AXES];
    logic signed [31:0]  ld_vel  [psw_pkg::NUM_AXES];
    logic signed [31:0]  pos     [psw_pkg::NUM_AXES];
    logic signed [31:0]  vel     [psw_pkg::NUM_AXES];
    logic [2:0]          bounce;

    assign in_beat = s_valid && s_ready;
    assign s_ready = (state_reg == psw_pkg::ST_IDLE);
    assign commit  = (state_reg == psw_pkg::ST_SUM) && (!m_valid_reg || m_ready);

    // wall registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walls_reg[psw_pkg::REG_X_LOW]  <= psw_pkg::WALL_LOW_RST;
            walls_reg[psw_pkg::REG_X_HIGH] <= psw_pkg::WALL_HIGH_RST;
            walls_reg[psw_pkg::REG_Y_LOW]  <= psw_pkg::WALL_LOW_RST;
            walls_reg[psw_pkg::REG_Y_HIGH] <= psw_pkg::WALL_HIGH_RST;
            walls_reg[psw_pkg::REG_Z_LOW]  <= psw_pkg::WALL_LOW_RST;
            walls_reg[psw_pkg::REG_Z_HIGH] <= psw_pkg::WALL_HIGH_RST;
        end else if (cfg_wr_en && (32'(cfg_index) < psw_pkg::NUM_WALLS)) begin
            walls_reg[cfg_index] <= cfg_wdata;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psw_pkg::ST_IDLE: begin
                if (in_beat) state_next = psw_pkg::ST_PROD;
            end
            psw_pkg::ST_PROD: begin
                state_next = psw_pkg::ST_ACC;
            end
            psw_pkg::ST_ACC: begin
                state_next = psw_pkg::ST_SUM;
            end
            psw_pkg::ST_SUM: begin
                if (commit) state_next = psw_pkg::ST_IDLE;
            end
            default: begin
                state_next = psw_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid: set on commit, cleared when the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item kind and shared dt squared, captured with the beat
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            kind_reg    <= s_kind;
            step_sq_reg <= 32'(s_step_time) * 32'(s_step_time);
        end
    end

    // stage enables for the lanes
    always_comb begin
        lane_ctrl.capture = in_beat;
        lane_ctrl.acc_en  = (state_reg == psw_pkg::ST_PROD);
        lane_ctrl.sum_en  = (state_reg == psw_pkg::ST_ACC);
        lane_ctrl.commit  = commit;
        lane_ctrl.is_load = (kind_reg == psw_pkg::KIND_LOAD);
    end

    assign accel[0]  = s_accel_x;
    assign accel[1]  = s_accel_y;
    assign accel[2]  = s_accel_z;
    assign ld_pos[0] = s_load_pos_x;
    assign ld_pos[1] = s_load_pos_y;
    assign ld_pos[2] = s_load_pos_z;
    assign ld_vel[0] = s_load_vel_x;
    assign ld_vel[1] = s_load_vel_y;
    assign ld_vel[2] = s_load_vel_z;

    // one lane per axis
    for (genvar i = 0; i < psw_pkg::NUM_AXES; i++) begin : g_lane
        psw_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .step_time (s_step_time),
            .step_sq   (step_sq_reg),
            .accel     (accel[i]),
            .load_pos  (ld_pos[i]),
            .load_vel  (ld_vel[i]),
            .wall_low  (walls_reg[2*i]),
            .wall_high (walls_reg[2*i+1]),
            .pos       (pos[i]),
            .vel       (vel[i]),
            .bounce    (bounce[i])
        );
    end

    // merge: lane state is held until the next commit, which waits for the beat to go
    assign m_valid       = m_valid_reg;
    assign m_pos_x       = pos[0];
    assign m_pos_y       = pos[1];
    assign m_pos_z       = pos[2];
    assign m_vel_x       = vel[0];
    assign m_vel_y       = vel[1];
    assign m_vel_z       = vel[2];
    assign m_bounce_mask = {bounce[2], bounce[1], bounce[0]};

`ifndef SYNTHESIS
    // an accepted beat starts the product stage and blocks further input
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == psw_pkg::ST_PROD) && !s_ready)
        else $error("accepted beat did not start the lanes");

    // a load result never reports a wall hit
    a_load_no_bounce: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && kind_reg == psw_pkg::KIND_LOAD) |=> (m_bounce_mask == 3'b000))
        else $error("load result carries a bounce");

    // a new result appears only out of the sum stage
    a_valid_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == psw_pkg::ST_SUM))
        else $error("result valid without a finished item");

    // sequencer state stays one-hot
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
`endif

endmodule

[sim/psw_checker.sv]
// scoreboard for the particle step block: mirrors walls and particle state, checks result beats
module psw_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_kind,
    input  logic [15:0]        s_step_time,
    input  logic signed [31:0] s_accel_x,
    input  logic signed [31:0] s_accel_y,
    input  logic signed [31:0] s_accel_z,
    input  logic signed [31:0] s_load_pos_x,
    input  logic signed [31:0] s_load_pos_y,
    input  logic signed [31:0] s_load_pos_z,
    input  logic signed [31:0] s_load_vel_x,
    input  logic signed [31:0] s_load_vel_y,
    input  logic signed [31:0] s_load_vel_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_pos_x,
    input  logic signed [31:0] m_pos_y,
    input  logic signed [31:0] m_pos_z,
    input  logic signed [31:0] m_vel_x,
    input  logic signed [31:0] m_vel_y,
    input  logic signed [31:0] m_vel_z,
    input  logic [2:0]         m_bounce_mask,
    output int                 mismatch_count,
    output int                 results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] pos [psw_pkg::NUM_AXES];
        logic [31:0] vel [psw_pkg::NUM_AXES];
        logic [2:0]  mask;
    } particle_state_t;

    // predicted results in acceptance order
    particle_state_t owed_states [$];

    // mirrored wall registers and particle state, kept wide
    longint wall_q  [psw_pkg::NUM_WALLS];
    longint pos_now [psw_pkg::NUM_AXES];
    longint vel_now [psw_pkg::NUM_AXES];

    // clamp into the signed 32-bit range
    function automatic longint sat_q16(input longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // exact constant-acceleration update of one axis, then the wall test
    function automatic void advance_axis(inout longint p, inout longint v, input longint a,
                                         input longint d, input longint lo, input longint hi,
                                         output logic hit);
        longint half_acc;
        longint dpos;
        longint dv;
        // arithmetic shifts give floor division on negative values
        half_acc = (a * (d * d)) >>> 17;
        dpos     = (v * d + half_acc + 32768) >>> 16;
        dv       = (a * d + 32768) >>> 16;
        p        = sat_q16(p + dpos);
        v        = sat_q16(v + dv);
        hit      = 1'b0;
        // low wall wins when the walls are crossed
        if (p < lo) begin
            p   = lo;
            v   = sat_q16(-v);
            hit = 1'b1;
        end else if (p > hi) begin
            p   = hi;
            v   = sat_q16(-v);
            hit = 1'b1;
        end
    endfunction

    function automatic void check_field(input string tag, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, tag, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        particle_state_t head;
        particle_state_t want;
        longint          acc [psw_pkg::NUM_AXES];
        longint          lp  [psw_pkg::NUM_AXES];
        longint          lv  [psw_pkg::NUM_AXES];
        longint          d;
        logic            hit;
        int              i;

        if (!aresetn) begin
            for (i = 0; i < psw_pkg::NUM_AXES; i++) begin
                wall_q[psw_pkg::REG_X_LOW + 2 * i]  = psw_pkg::WALL_LOW_RST;
                wall_q[psw_pkg::REG_X_HIGH + 2 * i] = psw_pkg::WALL_HIGH_RST;
                pos_now[i] = 0;
                vel_now[i] = 0;
            end
            owed_states.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (owed_states.size() == 0) begin
                    $display("%0t: result beat with nothing predicted, got pos %h %h %h",
                             $time, m_pos_x, m_pos_y, m_pos_z);
                    mismatch_count++;
                end else begin
                    head = owed_states.pop_front();
                    check_field("pos_x", head.pos[0], m_pos_x);
                    check_field("pos_y", head.pos[1], m_pos_y);
                    check_field("pos_z", head.pos[2], m_pos_z);
                    check_field("vel_x", head.vel[0], m_vel_x);
                    check_field("vel_y", head.vel[1], m_vel_y);
                    check_field("vel_z", head.vel[2], m_vel_z);
                    check_field("bounce_mask", 32'(head.mask), 32'(m_bounce_mask));
                end
            end

            // wall writes, indexes past the last wall are dropped
            if (cfg_wr_en && cfg_index < psw_pkg::NUM_WALLS) begin
                wall_q[cfg_index] = longint'($signed(cfg_wdata));
            end

            // input beat advances the mirrored particle
            if (s_valid && s_ready) begin
                acc = '{s_accel_x, s_accel_y, s_accel_z};
                lp  = '{s_load_pos_x, s_load_pos_y, s_load_pos_z};
                lv  = '{s_load_vel_x, s_load_vel_y, s_load_vel_z};
                want.mask = '0;
                if (s_kind == psw_pkg::KIND_LOAD) begin
                    for (i = 0; i < psw_pkg::NUM_AXES; i++) begin
                        pos_now[i] = lp[i];
                        vel_now[i] = lv[i];
                    end
                end else begin
                    d = longint'(s_step_time);
                    for (i = 0; i < psw_pkg::NUM_AXES; i++) begin
                        advance_axis(pos_now[i], vel_now[i], acc[i], d,
                                     wall_q[psw_pkg::REG_X_LOW + 2 * i],
                                     wall_q[psw_pkg::REG_X_HIGH + 2 * i], hit);
                        want.mask[i] = hit;
                    end
                end
                for (i = 0; i < psw_pkg::NUM_AXES; i++) begin
                    want.pos[i] = pos_now[i][31:0];
                    want.vel[i] = vel_now[i][31:0];
                end
                owed_states.insert(owed_states.size(), want);
            end
        end
        results_owed <= owed_states.size();
    end

endmodule

[sim/tb_particle_step_with_wall_bounce.sv]
// testbench top for the particle step block: clock, reset, wall setup, stimulus and verdict
module tb_particle_step_with_wall_bounce;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          Q1               = 65536;
    localparam logic [31:0] Q_MAX            = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN            = 32'h8000_0000;
    localparam int unsigned GAP_MAX          = 18;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT      = 4000;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int          ITEMS_PER_PHASE  = 90;
    localparam int unsigned ACC_SPAN         = 20 * Q1;
    localparam int unsigned POS_SPAN         = 120 * Q1;
    localparam int unsigned VEL_SPAN         = 60 * Q1;

    typedef enum {
        WALLS_RESET,
        WALLS_BOX,
        WALLS_TIGHT,
        WALLS_WIDE,
        WALLS_ANY
    } wall_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [15:0]        s_step_time;
    logic signed [31:0] s_accel_x;
    logic signed [31:0] s_accel_y;
    logic signed [31:0] s_accel_z;
    logic signed [31:0] s_load_pos_x;
    logic signed [31:0] s_load_pos_y;
    logic signed [31:0] s_load_pos_z;
    logic signed [31:0] s_load_vel_x;
    logic signed [31:0] s_load_vel_y;
    logic signed [31:0] s_load_vel_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_pos_z;
    logic signed [31:0] m_vel_x;
    logic signed [31:0] m_vel_y;
    logic signed [31:0] m_vel_z;
    logic [2:0]         m_bounce_mask;
    int                 mismatch_count;
    int                 results_owed;

    logic [31:0] wall_plan [psw_pkg::NUM_WALLS];
    bit          src_lazy     = 1'b1;
    bit          sink_lazy    = 1'b1;
    bit          hold_sink    = 1'b0;
    int unsigned quiet_cycles = 0;

    particle_step_with_wall_bounce dut (.*);
    psw_checker scoreboard (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : sink
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                hold_sink = 1'b0;
            end else begin
                stall = sink_lazy ? $urandom_range(0, GAP_MAX) : 0;
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic logic [95:0] trio(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [95:0] noise3();
        return {$urandom, $urandom, $urandom};
    endfunction

    // mostly values near the working range, some full-range and saturating ones
    function automatic logic [31:0] pick_value(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return Q_MAX;
        end
        if (r == 1) begin
            return Q_MIN;
        end
        if (r <= 4) begin
            return $urandom;
        end
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // one input beat after a random gap, returns at its acceptance edge
    task automatic offer_beat(input logic kind, input logic [15:0] dt, input logic [95:0] acc,
                              input logic [95:0] pos, input logic [95:0] vel);
        int unsigned gap;
        gap = src_lazy ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_step_time  <= dt;
        s_accel_x    <= acc[31:0];
        s_accel_y    <= acc[63:32];
        s_accel_z    <= acc[95:64];
        s_load_pos_x <= pos[31:0];
        s_load_pos_y <= pos[63:32];
        s_load_pos_z <= pos[95:64];
        s_load_vel_x <= vel[31:0];
        s_load_vel_y <= vel[63:32];
        s_load_vel_z <= vel[95:64];
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    task automatic plan_walls(input wall_mode_t mode);
        int ax;
        for (ax = 0; ax < psw_pkg::NUM_AXES; ax++) begin
            case (mode)
                WALLS_RESET: begin
                    wall_plan[psw_pkg::REG_X_LOW + 2 * ax]  = psw_pkg::WALL_LOW_RST;
                    wall_plan[psw_pkg::REG_X_HIGH + 2 * ax] = psw_pkg::WALL_HIGH_RST;
                end
                WALLS_BOX: begin
                    wall_plan[psw_pkg::REG_X_LOW + 2 * ax]  = -$urandom_range(Q1, 200 * Q1);
                    wall_plan[psw_pkg::REG_X_HIGH + 2 * ax] = $urandom_range(Q1, 200 * Q1);
                end
                WALLS_TIGHT: begin
                    wall_plan[psw_pkg::REG_X_LOW + 2 * ax]  = -$urandom_range(0, Q1);
                    wall_plan[psw_pkg::REG_X_HIGH + 2 * ax] = $urandom_range(0, Q1);
                end
                WALLS_WIDE: begin
                    wall_plan[psw_pkg::REG_X_LOW + 2 * ax]  = Q_MIN;
                    wall_plan[psw_pkg::REG_X_HIGH + 2 * ax] = Q_MAX;
                end
                default: begin
                    wall_plan[psw_pkg::REG_X_LOW + 2 * ax]  = $urandom;
                    wall_plan[psw_pkg::REG_X_HIGH + 2 * ax] = $urandom;
                end
            endcase
        end
    endtask

    // write all walls, then the unused indexes with junk that must be dropped
    task automatic load_walls();
        int i;
        for (i = 0; i < psw_pkg::NUM_WALLS + 2; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= (i < psw_pkg::NUM_WALLS) ? wall_plan[i] : $urandom;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit squeeze);
        int          n;
        int unsigned r;
        logic        kind;
        logic [15:0] dt;
        for (n = 0; n < count; n++) begin
            // idling comes in stretches, some with none at all
            if (n % 30 == 0) begin
                src_lazy  = ($urandom_range(0, 2) != 0);
                sink_lazy = ($urandom_range(0, 2) != 0);
            end
            // back-to-back beats into a stalled result side
            if (squeeze && n == 0) begin
                src_lazy  = 1'b0;
                hold_sink = 1'b1;
            end
            kind = ($urandom_range(0, 7) == 0) ? psw_pkg::KIND_LOAD : psw_pkg::KIND_STEP;
            r    = $urandom_range(0, 9);
            dt   = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            offer_beat(kind, dt,
                       trio(pick_value(ACC_SPAN), pick_value(ACC_SPAN), pick_value(ACC_SPAN)),
                       trio(pick_value(POS_SPAN), pick_value(POS_SPAN), pick_value(POS_SPAN)),
                       trio(pick_value(VEL_SPAN), pick_value(VEL_SPAN), pick_value(VEL_SPAN)));
        end
    endtask

    initial begin : stimulus
        wall_mode_t phase_plan [5];
        int         ph;

        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_kind       = psw_pkg::KIND_STEP;
        s_step_time  = '0;
        s_accel_x    = '0;
        s_accel_y    = '0;
        s_accel_z    = '0;
        s_load_pos_x = '0;
        s_load_pos_y = '0;
        s_load_pos_z = '0;
        s_load_vel_x = '0;
        s_load_vel_y = '0;
        s_load_vel_z = '0;
        aresetn      = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // resting particle, longest step, no acceleration
        offer_beat(psw_pkg::KIND_STEP, 16'hFFFF, trio(0, 0, 0), noise3(), noise3());
        // load with junk in the step fields
        offer_beat(psw_pkg::KIND_LOAD, 16'hFFFF, noise3(), trio(Q1, -2 * Q1, 7 * Q1 / 2),
                   trio(10 * Q1, -5 * Q1, 0));
        // half-second step under ordinary accelerations
        offer_beat(psw_pkg::KIND_STEP, 16'd32768, trio(Q1, -642253, Q1 / 2), noise3(),
                   noise3());
        // shortest step with the smallest accelerations
        offer_beat(psw_pkg::KIND_STEP, 16'd1, trio(1, -1, 0), noise3(), noise3());
        // rounding ties go toward plus infinity
        offer_beat(psw_pkg::KIND_LOAD, 16'd0, noise3(), trio(0, 0, 0), trio(0, 0, 0));
        offer_beat(psw_pkg::KIND_STEP, 16'd32768, trio(1, -1, 3), noise3(), noise3());
        // strongest accelerations over the longest step
        offer_beat(psw_pkg::KIND_STEP, 16'hFFFF, trio(Q_MAX, Q_MIN, Q_MAX), noise3(), noise3());
        // bounce off the high and the low wall
        offer_beat(psw_pkg::KIND_LOAD, 16'd0, noise3(), trio(199 * Q1 / 2, -199 * Q1 / 2, 0),
                   trio(2 * Q1, -2 * Q1, 0));
        offer_beat(psw_pkg::KIND_STEP, 16'hFFFF, trio(0, 0, 0), noise3(), noise3());
        // load the extremes, then bounce with the most negative velocity
        offer_beat(psw_pkg::KIND_LOAD, 16'd0, noise3(), trio(Q_MIN, Q_MAX, 0),
                   trio(Q_MIN, Q_MAX, Q_MIN));
        offer_beat(psw_pkg::KIND_STEP, 16'd0, trio(0, 0, 0), noise3(), noise3());

        // walls at the range limits so sums saturate without a bounce
        wait_drained();
        plan_walls(WALLS_WIDE);
        load_walls();
        offer_beat(psw_pkg::KIND_LOAD, 16'd0, noise3(), trio(32'h7FFF_0000, 32'h8001_0000, 0),
                   trio(Q_MAX, Q_MIN, 0));
        offer_beat(psw_pkg::KIND_STEP, 16'hFFFF, trio(Q_MAX, Q_MIN, Q_MAX), noise3(), noise3());
        offer_beat(psw_pkg::KIND_STEP, 16'hFFFF, trio(Q_MAX, Q_MIN, Q_MAX), noise3(), noise3());

        // crossed walls on x and z, zero-width box on y
        wait_drained();
        wall_plan[psw_pkg::REG_X_LOW]  = 10 * Q1;
        wall_plan[psw_pkg::REG_X_HIGH] = -10 * Q1;
        wall_plan[psw_pkg::REG_Y_LOW]  = 0;
        wall_plan[psw_pkg::REG_Y_HIGH] = 0;
        wall_plan[psw_pkg::REG_Z_LOW]  = 5 * Q1;
        wall_plan[psw_pkg::REG_Z_HIGH] = -5 * Q1;
        load_walls();
        offer_beat(psw_pkg::KIND_LOAD, 16'd0, noise3(), trio(0, 3 * Q1, 20 * Q1),
                   trio(Q1, Q1, Q1));
        offer_beat(psw_pkg::KIND_STEP, 16'd0, trio(0, 0, 0), noise3(), noise3());
        offer_beat(psw_pkg::KIND_STEP, 16'd16384, trio(-Q1, Q1, 0), noise3(), noise3());

        // random phases, each under its own walls
        phase_plan = '{WALLS_BOX, WALLS_TIGHT, WALLS_RESET, WALLS_ANY, WALLS_WIDE};
        for (ph = 0; ph < 5; ph++) begin
            wait_drained();
            plan_walls(phase_plan[ph]);
            load_walls();
            run_random(ITEMS_PER_PHASE, ph == 2);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
